[sv/page_bitmap_allocator_unit_assert.svh]
// Assertion macros for the page bitmap allocator.
// Each macro expands to one labelled concurrent assertion clocked on clk,
// held off while rst_n is low.
`ifndef PAGE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pba_pkg.sv]
`default_nettype none
package pba_pkg;

  localparam int PBA_MAX_PAGES     = 32768;
  localparam int PBA_RESERVED_LAST = 512;
  localparam logic [15:0] PBA_TOTAL_RESET = 16'd32768;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_TEST  = 2'd3
  } pba_mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2
  } pba_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_MOD,
    S_SCAN,
    S_FIN
  } pba_state_t;

  typedef struct packed {
    logic       found;
    logic [2:0] idx;
  } pba_zero_t;

  // Lowest clear bit of a map byte.
  function automatic pba_zero_t pba_first_zero(input logic [7:0] w);
    pba_zero_t r;
    r = '0;
    for (int k = 7; k >= 0; k--) begin
      if (!w[k]) begin
        r.found = 1'b1;
        r.idx   = 3'(k);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/page_bitmap_allocator_unit.sv]
// Page bitmap allocator: one used bit per physical page, a free-page count
// and a next-free pointer, all kept around a byte-wide map RAM.
// Channels: in_* takes an operation (in_tuser = mode, in_tdata = page),
// out_* returns exactly one result per operation, cfg_* writes total_pages
// and is always ready. All transfers complete on tvalid & tready (cfg: valid
// & ready) at a rising edge of clk.
// Operations: clear and test read the map byte holding the page, then clear
//   or test the bit; range failures skip the map. Allocate marks the pointed
//   page, then scans on for the next clear bit; the scan reads one byte a
//   cycle from the map RAM. Init writes all MAX_PAGES/8 map bytes, one map
//   byte written a cycle.
// One operation is in flight at a time; the next input transfer is taken
// while the previous result still waits in the output register.
// Reset (rst_n low, synchronous) zeroes count and pointer, then a clearing
// pass writes zero to all MAX_PAGES/8 map bytes; no input is taken during
// it, configuration writes are.
// When the receiver stalls, the result holds in the output register and a
// finished operation waits before retiring into it.
`default_nettype none
`include "page_bitmap_allocator_unit_assert.svh"
module page_bitmap_allocator_unit
  import pba_pkg::*;
#(
  parameter int MAX_PAGES     = PBA_MAX_PAGES,
  parameter int RESERVED_LAST = PBA_RESERVED_LAST
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input operations
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [14:0] page_number, [15] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] mode
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // [14:0] page_out, [15] bit_value,
                                       // [31:16] free_pages
  output logic      [1:0]  out_tuser,  // [1:0] status
  // configuration: total_pages
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  localparam int PAGE_W = $clog2(MAX_PAGES);
  localparam int DEPTH  = (MAX_PAGES + 7) / 8;
  localparam int AW     = PAGE_W - 3;

  // state and control
  pba_state_t      state_r, state_nxt;
  logic [AW-1:0]   sweep_cnt_r, sweep_cnt_nxt;
  logic            fill_init_r, fill_init_nxt;
  pba_mode_t       op_r, op_nxt;
  logic [2:0]      bit_r, bit_nxt;
  logic [AW-1:0]   scan_w_r, scan_w_nxt;
  logic [15:0]     next_free_r, next_free_nxt;
  logic [15:0]     free_count_r, free_count_nxt;
  logic [15:0]     total_pages_r;

  // pending result
  logic [14:0]     res_page_r, res_page_nxt;
  logic            res_bit_r, res_bit_nxt;
  pba_status_t     res_status_r, res_status_nxt;

  // output register
  logic            out_valid_r, out_valid_nxt;
  logic [14:0]     out_page_r, out_page_nxt;
  logic            out_bit_r, out_bit_nxt;
  logic [15:0]     out_free_r, out_free_nxt;
  pba_status_t     out_status_r, out_status_nxt;

  // map RAM
  logic            ram_we;
  logic [AW-1:0]   ram_wr_addr;
  logic [7:0]      ram_wr_data;
  logic            ram_rd_en;
  logic [AW-1:0]   ram_rd_addr;
  logic [7:0]      ram_rd_data;

  // helpers
  logic [15:0]     n_pages;
  logic [7:0]      init_pat;
  logic [7:0]      set_mask;
  logic [7:0]      skip_mask;
  logic [7:0]      scan_word;
  pba_zero_t       fz;
  logic [PAGE_W-1:0] hit_page;
  logic            hit_in_range;
  logic            more_words;
  pba_mode_t       in_mode;
  logic [14:0]     in_page;

  pba_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_map (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_mode   = pba_mode_t'(in_tuser);
  assign in_page   = in_tdata[14:0];
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_free_r, out_bit_r, out_page_r};
  assign out_tuser  = out_status_r;

  // pages in effect: min(total_pages, MAX_PAGES)
  always_comb begin
    if (32'(total_pages_r) < 32'(MAX_PAGES)) begin
      n_pages = total_pages_r;
    end else begin
      n_pages = 16'(MAX_PAGES);
    end
  end

  // init fill pattern: bits up to RESERVED_LAST set
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      init_pat[k] = (32'({sweep_cnt_r, 3'(k)}) <= 32'(RESERVED_LAST));
    end
  end

  // forward scan over one map byte; in MOD the byte is the one just marked,
  // with bits up to the allocated page skipped
  assign set_mask  = 8'b1 << bit_r;
  assign skip_mask = 8'((9'b10 << bit_r) - 9'd1);
  assign scan_word = (state_r == S_MOD) ? (ram_rd_data | skip_mask) : ram_rd_data;
  assign fz        = pba_first_zero(scan_word);
  assign hit_page  = {scan_w_r, fz.idx};
  assign hit_in_range = 32'(hit_page) < 32'(n_pages);
  assign more_words   = ((32'(scan_w_r) << 3) + 32'd8) < 32'(n_pages);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_SWEEP;
      sweep_cnt_r   <= '0;
      fill_init_r   <= 1'b0;
      next_free_r   <= '0;
      free_count_r  <= '0;
      total_pages_r <= PBA_TOTAL_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_cnt_r  <= sweep_cnt_nxt;
      fill_init_r  <= fill_init_nxt;
      next_free_r  <= next_free_nxt;
      free_count_r <= free_count_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        total_pages_r <= cfg_data;
      end
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    bit_r        <= bit_nxt;
    scan_w_r     <= scan_w_nxt;
    res_page_r   <= res_page_nxt;
    res_bit_r    <= res_bit_nxt;
    res_status_r <= res_status_nxt;
    out_page_r   <= out_page_nxt;
    out_bit_r    <= out_bit_nxt;
    out_free_r   <= out_free_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    sweep_cnt_nxt  = sweep_cnt_r;
    fill_init_nxt  = fill_init_r;
    op_nxt         = op_r;
    bit_nxt        = bit_r;
    scan_w_nxt     = scan_w_r;
    next_free_nxt  = next_free_r;
    free_count_nxt = free_count_r;
    res_page_nxt   = res_page_r;
    res_bit_nxt    = res_bit_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_page_nxt   = out_page_r;
    out_bit_nxt    = out_bit_r;
    out_free_nxt   = out_free_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_wr_addr    = scan_w_r;
    ram_wr_data    = ram_rd_data;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = scan_w_r + AW'(1);
    in_tready      = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt         = in_mode;
          res_page_nxt   = '0;
          res_bit_nxt    = 1'b0;
          res_status_nxt = ST_OK;
          case (in_mode)
            MODE_INIT: begin
              sweep_cnt_nxt = '0;
              fill_init_nxt = 1'b1;
              state_nxt     = S_SWEEP;
            end
            MODE_ALLOC: begin
              if (32'(next_free_r) >= 32'(n_pages)) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_FIN;
              end else begin
                // fetch the byte holding the pointed page
                scan_w_nxt  = AW'(next_free_r >> 3);
                bit_nxt     = next_free_r[2:0];
                ram_rd_en   = 1'b1;
                ram_rd_addr = AW'(next_free_r >> 3);
                state_nxt   = S_MOD;
              end
            end
            default: begin
              if (32'(in_page) >= 32'(n_pages)) begin
                res_status_nxt = ST_RANGE;
                state_nxt      = S_FIN;
              end else begin
                scan_w_nxt  = AW'(in_page >> 3);
                bit_nxt     = in_page[2:0];
                ram_rd_en   = 1'b1;
                ram_rd_addr = AW'(in_page >> 3);
                state_nxt   = S_MOD;
              end
            end
          endcase
        end
      end

      S_SWEEP: begin
        ram_we      = 1'b1;
        ram_wr_addr = sweep_cnt_r;
        ram_wr_data = fill_init_r ? init_pat : 8'h00;
        if (sweep_cnt_r == AW'(DEPTH - 1)) begin
          if (fill_init_r) begin
            if (32'(n_pages) > 32'(RESERVED_LAST + 1)) begin
              free_count_nxt = n_pages - 16'(RESERVED_LAST + 1);
            end else begin
              free_count_nxt = '0;
            end
            next_free_nxt = 16'(RESERVED_LAST + 1);
            state_nxt     = S_FIN;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          sweep_cnt_nxt = sweep_cnt_r + AW'(1);
        end
      end

      S_MOD, S_SCAN: begin
        if (state_r == S_MOD && op_r == MODE_CLEAR) begin
          ram_we      = 1'b1;
          ram_wr_data = ram_rd_data & ~set_mask;
          state_nxt   = S_FIN;
        end else if (state_r == S_MOD && op_r == MODE_TEST) begin
          res_bit_nxt = ram_rd_data[bit_r];
          state_nxt   = S_FIN;
        end else begin
          if (state_r == S_MOD) begin
            // mark the handed-out page, count it off
            ram_we       = 1'b1;
            ram_wr_data  = ram_rd_data | set_mask;
            res_page_nxt = 15'(next_free_r);
            if (free_count_r != 16'd0) begin
              free_count_nxt = free_count_r - 16'd1;
            end
          end
          // advance the pointer to the next clear bit, stop at n
          if (fz.found) begin
            next_free_nxt = hit_in_range ? 16'(hit_page) : n_pages;
            state_nxt     = S_FIN;
          end else if (!more_words) begin
            next_free_nxt = n_pages;
            state_nxt     = S_FIN;
          end else begin
            ram_rd_en  = 1'b1;
            scan_w_nxt = scan_w_r + AW'(1);
            state_nxt  = S_SCAN;
          end
        end
      end

      S_FIN: begin
        // retire into the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_page_nxt   = res_page_r;
          out_bit_nxt    = res_bit_r;
          out_free_nxt   = free_count_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // free count only falls outside an init or reset sweep
  `PBA_ASSERT_NEXT(a_count_falls, state_r != S_SWEEP,
                   free_count_r <= $past(free_count_r), "free count grew outside init")
  // pointer only moves forward outside an init or reset sweep
  `PBA_ASSERT_NEXT(a_ptr_forward, state_r != S_SWEEP,
                   next_free_r >= $past(next_free_r), "next-free pointer moved back")
  // a new result appears only after an operation retires
  `PBA_ASSERT_NOW(a_result_source, $rose(out_valid_r),
                  $past(state_r) == S_FIN, "result without a retiring operation")
  // map is never written while waiting for input
  `PBA_ASSERT_NOW(a_idle_no_write, state_r == S_IDLE, !ram_we, "map write while idle")

endmodule
`default_nettype wire

[sv/pba_ram.sv]
`default_nettype none
module pba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
